@@ sv/bitmap_text_renderer_assert.svh @@
// Assertion macros shared by the text renderer RTL.
`ifndef BITMAP_TEXT_RENDERER_ASSERT_SVH
`define BITMAP_TEXT_RENDERER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BTR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define BTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/btr_pkg.sv @@
// Shared types, constants and mask helpers for the text renderer.
package btr_pkg;

    localparam int STORE_DEPTH = 2048;
    localparam int ADDR_W      = 11;
    localparam int MAX_STRIPS  = 32;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_CHAR  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_BOX_LEFT     = 3'd0,
        REG_BOX_TOP      = 3'd1,
        REG_BOX_RIGHT    = 3'd2,
        REG_BOX_BOTTOM   = 3'd3,
        REG_SCALE        = 3'd4,
        REG_LINE_LEADING = 3'd5,
        REG_CHAR_SPACING = 3'd6,
        REG_DRAW_COLOR   = 3'd7
    } reg_index_t;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_WRAP   = 11'b000_0000_0010,
        S_ADVY1  = 11'b000_0000_0100,
        S_ADVY2  = 11'b000_0000_1000,
        S_BOTTOM = 11'b000_0001_0000,
        S_RD0    = 11'b000_0010_0000,
        S_RD1    = 11'b000_0100_0000,
        S_RD2    = 11'b000_1000_0000,
        S_EMIT   = 11'b001_0000_0000,
        S_FIN1   = 11'b010_0000_0000,
        S_FIN2   = 11'b100_0000_0000
    } state_t;

    // Spread each bit of a column byte over s mask bits; band 1 sits 8*s higher, and is cleared at s = 4.
    function automatic logic [31:0] expand_band(input logic [7:0] col, input logic [2:0] s,
                                                input logic band);
        logic [31:0] m;
        m = '0;
        for (int j = 0; j < 8; j++) begin
            case (s)
                3'd2: begin
                    m[2*j]   = col[j];
                    m[2*j+1] = col[j];
                end
                3'd3: begin
                    m[3*j]   = col[j];
                    m[3*j+1] = col[j];
                    m[3*j+2] = col[j];
                end
                3'd4: begin
                    m[4*j]   = col[j];
                    m[4*j+1] = col[j];
                    m[4*j+2] = col[j];
                    m[4*j+3] = col[j];
                end
                default: begin
                    m[j] = col[j];
                end
            endcase
        end
        if (band) begin
            case (s)
                3'd2:    m = m << 16;
                3'd3:    m = m << 24;
                3'd4:    m = '0;
                default: m = m << 8;
            endcase
        end
        return m;
    endfunction

endpackage

@@ sv/btr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bitmap_text_renderer.sv @@
// Bitmap font text renderer: glyph store, text cursor with box wrap, column strips.
//
// Input stream (s_*): one beat per command. tuser selects the kind: load a glyph
// byte into the 2048 x 8 store, start a string, or place one character. tlast on
// a character beat marks the last character the string may use.
// Output stream (m_*): one beat per scaled pixel column of a drawn glyph, with x,
// top y, a 32-bit vertical mask, color and character index; tlast marks the last
// beat of the character. A halt beat (tuser high, zero mask) ends a string whose
// next character would reach the bottom of the box.
// Loads, starts, ended or idle characters are taken in S_IDLE and give no beat.
// A drawn character, a dropped blank or a halt holds s_tready low after its beat
// until the sequencer is back in S_IDLE.
// The store read port paces each column: one read per row band, then one
// beat per cycle while the receiver takes them; output stalls hold the sequencer.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset restores the register defaults, puts the cursor at the box origin and
// marks no string active. The glyph store is not cleared and must be loaded.
// APB port: registers at byte offsets 4*i, written on the access cycle.
module bitmap_text_renderer #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 8,
    parameter int GLYPH_COUNT  = 256,
    parameter int MAX_SCALE    = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // glyph_address[10:0], glyph_byte[18:11], char_code[26:19]
    input  logic [1:0]  s_tuser,  // action[1:0]
    input  logic        s_tlast,  // final_char
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // column_x[7:0], top_y[15:8], column_mask[47:16],
                                  // pixel_color[48], chars_taken[56:49]
    output logic        m_tuser,  // halted
    output logic        m_tlast   // last
);

    `include "bitmap_text_renderer_assert.svh"

    localparam int ROWS   = GLYPH_HEIGHT / 8;
    localparam int GLEN   = GLYPH_WIDTH * ROWS;
    localparam int COL_W  = $clog2(GLYPH_WIDTH + 1);
    localparam int CNT_W  = $clog2(btr_pkg::MAX_STRIPS + 1);

    // configuration registers
    logic [7:0] box_left_reg, box_top_reg, box_right_reg, box_bottom_reg;
    logic [2:0] scale_reg;
    logic [7:0] line_leading_reg, char_spacing_reg;
    logic       draw_color_reg;

    // sequencer state
    btr_pkg::state_t state_reg, state_next;
    logic [7:0]  cursor_x_reg, cursor_x_next;
    logic [7:0]  cursor_y_reg, cursor_y_next;
    logic [7:0]  char_index_reg, char_index_next;
    logic        done_reg, done_next;
    logic [7:0]  code_reg, code_next;
    logic        fin_reg, fin_next;
    logic [7:0]  tmp_reg, tmp_next;
    logic [btr_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [1:0]  rep_reg, rep_next;
    logic [CNT_W-1:0] strip_cnt_reg, strip_cnt_next;
    logic [7:0]  strip_x_reg, strip_x_next;
    logic [31:0] mask_reg, mask_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;
    logic        m_halt_reg, m_halt_next;
    logic        m_last_reg, m_last_next;

    // input beat fields
    logic                       s_beat;
    btr_pkg::action_t           in_action;
    logic [btr_pkg::ADDR_W-1:0] in_addr;
    logic [7:0]                 in_byte, in_code;

    assign s_beat    = s_tvalid && s_tready;
    assign in_action = btr_pkg::action_t'(s_tuser);
    assign in_addr   = s_tdata[10:0];
    assign in_byte   = s_tdata[18:11];
    assign in_code   = s_tdata[26:19];

    // scale clamp and glyph extents
    logic [2:0] eff_s;
    logic [7:0] gw, gh;
    always_comb begin
        if (scale_reg == 3'd0) begin
            eff_s = 3'd1;
        end else if (32'(scale_reg) > MAX_SCALE) begin
            eff_s = 3'(MAX_SCALE);
        end else begin
            eff_s = scale_reg;
        end
    end
    assign gw = 8'(GLYPH_WIDTH * 32'(eff_s));
    assign gh = 8'(GLYPH_HEIGHT * 32'(eff_s));

    // character code to glyph slot, worked out at elaboration
    logic [7:0] mod_tab [256];
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign mod_tab[g] = 8'(g % GLYPH_COUNT);
    end

    logic [btr_pkg::ADDR_W-1:0] base_addr;
    assign base_addr = btr_pkg::ADDR_W'(32'(mod_tab[code_reg]) * GLEN);

    // glyph store
    logic [btr_pkg::ADDR_W-1:0] ram_raddr;
    logic [7:0]                 ram_rdata;
    logic                       ram_we;

    assign ram_we = s_beat && (in_action == btr_pkg::ACT_LOAD);

    btr_ram #(
        .WIDTH(8),
        .DEPTH(btr_pkg::STORE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(in_addr),
        .wdata(in_byte),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // shared adder for cursor arithmetic and edge compares
    logic [7:0] add_a, add_b;
    logic [8:0] add_sum;
    always_comb begin
        case (state_reg)
            btr_pkg::S_WRAP: begin
                add_a = cursor_x_reg;
                add_b = gw;
            end
            btr_pkg::S_ADVY1: begin
                add_a = cursor_y_reg;
                add_b = gh;
            end
            btr_pkg::S_ADVY2: begin
                add_a = tmp_reg;
                add_b = line_leading_reg;
            end
            btr_pkg::S_BOTTOM: begin
                add_a = cursor_y_reg;
                add_b = gh;
            end
            btr_pkg::S_FIN1: begin
                add_a = cursor_x_reg;
                add_b = gw;
            end
            btr_pkg::S_FIN2: begin
                add_a = tmp_reg;
                add_b = char_spacing_reg;
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end
    assign add_sum = {1'b0, add_a} + {1'b0, add_b};

    logic slot_free, col_end, rep_end, emit_last, is_blank;
    assign slot_free = !m_valid_reg || m_tready;
    assign col_end   = (col_reg == COL_W'(GLYPH_WIDTH - 1));
    assign rep_end   = ({1'b0, rep_reg} == eff_s - 3'd1);
    assign emit_last = (strip_cnt_reg == CNT_W'(btr_pkg::MAX_STRIPS - 1)) || (col_end && rep_end);
    assign is_blank  = (code_reg == btr_pkg::CHAR_SPACE) || (code_reg == btr_pkg::CHAR_NL);

    always_comb begin
        state_next      = state_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        char_index_next = char_index_reg;
        done_next       = done_reg;
        code_next       = code_reg;
        fin_next        = fin_reg;
        tmp_next        = tmp_reg;
        addr_next       = addr_reg;
        col_next        = col_reg;
        rep_next        = rep_reg;
        strip_cnt_next  = strip_cnt_reg;
        strip_x_next    = strip_x_reg;
        mask_next       = mask_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_halt_next     = m_halt_reg;
        m_last_next     = m_last_reg;
        ram_raddr       = addr_reg;

        case (state_reg)
            btr_pkg::S_IDLE: begin
                if (s_beat) begin
                    case (in_action)
                        btr_pkg::ACT_START: begin
                            cursor_x_next   = box_left_reg;
                            cursor_y_next   = box_top_reg;
                            char_index_next = '0;
                            done_next       = 1'b0;
                        end
                        btr_pkg::ACT_CHAR: begin
                            if (!done_reg) begin
                                if (in_code == btr_pkg::CHAR_NUL) begin
                                    done_next = 1'b1;
                                end else begin
                                    code_next  = in_code;
                                    fin_next   = s_tlast;
                                    state_next = btr_pkg::S_WRAP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            btr_pkg::S_WRAP: begin
                if ((add_sum > {1'b0, box_right_reg}) || (code_reg == btr_pkg::CHAR_NL)) begin
                    cursor_x_next = box_left_reg;
                    state_next    = btr_pkg::S_ADVY1;
                end else begin
                    state_next = btr_pkg::S_BOTTOM;
                end
            end
            btr_pkg::S_ADVY1: begin
                tmp_next   = add_sum[7:0];
                state_next = btr_pkg::S_ADVY2;
            end
            btr_pkg::S_ADVY2: begin
                cursor_y_next = add_sum[7:0];
                if (is_blank) begin
                    // drop the blank that caused the wrap
                    char_index_next = char_index_reg + 8'd1;
                    done_next       = done_reg || fin_reg;
                    state_next      = btr_pkg::S_IDLE;
                end else begin
                    state_next = btr_pkg::S_BOTTOM;
                end
            end
            btr_pkg::S_BOTTOM: begin
                if (add_sum >= {1'b0, box_bottom_reg}) begin
                    if (slot_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {7'd0, char_index_reg, draw_color_reg, 32'd0,
                                        cursor_y_reg, cursor_x_reg};
                        m_halt_next  = 1'b1;
                        m_last_next  = 1'b1;
                        done_next    = 1'b1;
                        state_next   = btr_pkg::S_IDLE;
                    end
                end else begin
                    addr_next      = base_addr;
                    col_next       = '0;
                    rep_next       = '0;
                    strip_cnt_next = '0;
                    strip_x_next   = cursor_x_reg;
                    state_next     = btr_pkg::S_RD0;
                end
            end
            btr_pkg::S_RD0: begin
                ram_raddr  = addr_reg;
                state_next = btr_pkg::S_RD1;
            end
            btr_pkg::S_RD1: begin
                mask_next = btr_pkg::expand_band(ram_rdata, eff_s, 1'b0);
                ram_raddr = addr_reg + btr_pkg::ADDR_W'(GLYPH_WIDTH);
                if (ROWS > 1) begin
                    state_next = btr_pkg::S_RD2;
                end else begin
                    state_next = btr_pkg::S_EMIT;
                end
            end
            btr_pkg::S_RD2: begin
                mask_next  = mask_reg | btr_pkg::expand_band(ram_rdata, eff_s, 1'b1);
                state_next = btr_pkg::S_EMIT;
            end
            btr_pkg::S_EMIT: begin
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = {7'd0, char_index_reg, draw_color_reg, mask_reg,
                                      cursor_y_reg, strip_x_reg};
                    m_halt_next    = 1'b0;
                    m_last_next    = emit_last;
                    strip_x_next   = strip_x_reg + 8'd1;
                    strip_cnt_next = strip_cnt_reg + CNT_W'(1);
                    if (emit_last) begin
                        state_next = btr_pkg::S_FIN1;
                    end else if (rep_end) begin
                        rep_next   = '0;
                        col_next   = col_reg + COL_W'(1);
                        addr_next  = addr_reg + btr_pkg::ADDR_W'(1);
                        state_next = btr_pkg::S_RD0;
                    end else begin
                        rep_next = rep_reg + 2'd1;
                    end
                end
            end
            btr_pkg::S_FIN1: begin
                tmp_next   = add_sum[7:0];
                state_next = btr_pkg::S_FIN2;
            end
            btr_pkg::S_FIN2: begin
                cursor_x_next   = add_sum[7:0];
                char_index_next = char_index_reg + 8'd1;
                done_next       = done_reg || fin_reg;
                state_next      = btr_pkg::S_IDLE;
            end
            default: begin
                state_next = btr_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= btr_pkg::S_IDLE;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            char_index_reg <= '0;
            done_reg       <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            char_index_reg <= char_index_next;
            done_reg       <= done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        code_reg      <= code_next;
        fin_reg       <= fin_next;
        tmp_reg       <= tmp_next;
        addr_reg      <= addr_next;
        col_reg       <= col_next;
        rep_reg       <= rep_next;
        strip_cnt_reg <= strip_cnt_next;
        strip_x_reg   <= strip_x_next;
        mask_reg      <= mask_next;
        m_data_reg    <= m_data_next;
        m_halt_reg    <= m_halt_next;
        m_last_reg    <= m_last_next;
    end

    // configuration port
    logic             cfg_write;
    btr_pkg::reg_index_t cfg_index;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = btr_pkg::reg_index_t'(paddr[4:2]);
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_left_reg     <= 8'd0;
            box_top_reg      <= 8'd0;
            box_right_reg    <= 8'd127;
            box_bottom_reg   <= 8'd63;
            scale_reg        <= 3'd1;
            line_leading_reg <= 8'd1;
            char_spacing_reg <= 8'd1;
            draw_color_reg   <= 1'b1;
        end else if (cfg_write) begin
            case (cfg_index)
                btr_pkg::REG_BOX_LEFT:     box_left_reg     <= pwdata[7:0];
                btr_pkg::REG_BOX_TOP:      box_top_reg      <= pwdata[7:0];
                btr_pkg::REG_BOX_RIGHT:    box_right_reg    <= pwdata[7:0];
                btr_pkg::REG_BOX_BOTTOM:   box_bottom_reg   <= pwdata[7:0];
                btr_pkg::REG_SCALE:        scale_reg        <= pwdata[2:0];
                btr_pkg::REG_LINE_LEADING: line_leading_reg <= pwdata[7:0];
                btr_pkg::REG_CHAR_SPACING: char_spacing_reg <= pwdata[7:0];
                btr_pkg::REG_DRAW_COLOR:   draw_color_reg   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            btr_pkg::REG_BOX_LEFT:     prdata = {24'd0, box_left_reg};
            btr_pkg::REG_BOX_TOP:      prdata = {24'd0, box_top_reg};
            btr_pkg::REG_BOX_RIGHT:    prdata = {24'd0, box_right_reg};
            btr_pkg::REG_BOX_BOTTOM:   prdata = {24'd0, box_bottom_reg};
            btr_pkg::REG_SCALE:        prdata = {29'd0, scale_reg};
            btr_pkg::REG_LINE_LEADING: prdata = {24'd0, line_leading_reg};
            btr_pkg::REG_CHAR_SPACING: prdata = {24'd0, char_spacing_reg};
            btr_pkg::REG_DRAW_COLOR:   prdata = {31'd0, draw_color_reg};
            default:                   prdata = '0;
        endcase
    end

    assign s_tready = (state_reg == btr_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_halt_reg;
    assign m_tlast  = m_last_reg;

    // halt beat is the only beat of its character and plots nothing
    `BTR_ASSERT_NOW(a_halt_beat, m_tvalid && m_tuser, m_tlast && (m_tdata[47:16] == 32'd0),
        "halt beat without last or with a nonzero mask")
    // a character that starts work holds off the input
    `BTR_ASSERT_NEXT(a_char_busy,
        s_beat && (in_action == btr_pkg::ACT_CHAR) && !done_reg && (in_code != btr_pkg::CHAR_NUL),
        !s_tready, "input ready while a character is in flight")
    // never more strips than the cap
    `BTR_ASSERT_NOW(a_strip_cap, state_reg == btr_pkg::S_EMIT,
        strip_cnt_reg < CNT_W'(btr_pkg::MAX_STRIPS), "strip count past the cap")

endmodule
